// File: src/sle_pkg.sv
// sle_pkg: shared types and constants for the sorted list engine
// no dependencies; imported by every module under src
`timescale 1ns / 1ps

package sle_pkg;

  // default sizes, handed to the top level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  // stream payload layout
  localparam int OP_W     = 2;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int IN_W     = OP_W + VAL_W + POS_W;
  localparam int OUT_W    = STATUS_W + POS_W + VAL_W + COUNT_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL_POS = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;
  localparam logic [OP_W-1:0] OP_DEL_KEY = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic apply;
  } sle_cmd_t;

endpackage

// File: src/sle_ctrl.sv
// sle_ctrl: two-state controller sequencing accept and update of one transaction
// depends on sle_pkg
`timescale 1ns / 1ps

module sle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output sle_pkg::sle_cmd_t cmd_o
);
  import sle_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign s_axis_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.apply = (state_q == S_APPLY);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_APPLY;
      end
      S_APPLY: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_APPLY) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/sle_datapath.sv
// sle_datapath: row of sorted cells, parallel compare, one-step shift, result register
// depends on sle_pkg; driven by sle_ctrl commands
`timescale 1ns / 1ps

module sle_datapath #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sle_pkg::sle_cmd_t        cmd_i,
  input  logic [sle_pkg::IN_W-1:0]  in_data_i,
  output logic [sle_pkg::OUT_W-1:0] out_data_o
);
  import sle_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int XW    = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;

  // list cells and count
  logic signed [VALUE_BITS-1:0] cell_q [CAPACITY];
  logic [CNT_W-1:0]             count_q, count_d;

  // transaction fields
  logic [OP_W-1:0]              in_op;
  logic signed [VAL_W-1:0]      in_val32;
  logic signed [VALUE_BITS-1:0] in_val;
  logic [POS_W-1:0]             in_pos;

  // compare results
  logic [CAPACITY-1:0]          lt_d, hit_d, lt_q;
  logic [IDX_W-1:0]             found_d, found_q;
  logic                         any_q;
  logic [OP_W-1:0]              op_q;
  logic signed [VALUE_BITS-1:0] val_q;
  logic [POS_W-1:0]             pos_q;

  // update decode
  logic                         do_ins, do_del;
  logic [STATUS_W-1:0]          status;
  logic [POS_W-1:0]             found_out;
  logic [POS_W-1:0]             del_idx;
  logic signed [VALUE_BITS-1:0] rem_cell;
  logic signed [XW-1:0]         rem_ext;
  logic [VAL_W-1:0]             removed;
  logic [OUT_W-1:0]             out_q;

  assign in_op    = in_data_i[OP_W-1:0];
  assign in_val32 = signed'(in_data_i[OP_W+VAL_W-1:OP_W]);
  assign in_val   = VALUE_BITS'(in_val32);
  assign in_pos   = in_data_i[IN_W-1:OP_W+VAL_W];

  // parallel compare against every held cell
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_d[i]  = (CNT_W'(i) < count_q) && (cell_q[i] < in_val);
      hit_d[i] = (CNT_W'(i) < count_q) && (cell_q[i] == in_val);
    end
    found_d = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit_d[i]) found_d = IDX_W'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op;
      val_q   <= in_val;
      pos_q   <= in_pos;
      lt_q    <= lt_d;
      found_q <= found_d;
      any_q   <= |hit_d;
    end
  end

  // status and action for the held transaction
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    status    = ST_OK;
    found_out = '0;
    del_idx   = (op_q == OP_DEL_POS) ? pos_q : POS_W'(found_q);
    if (op_q == OP_INSERT) begin
      if (count_q >= CNT_W'(CAPACITY)) status = ST_FULL;
      else do_ins = 1'b1;
    end else if (count_q == '0) begin
      status = ST_EMPTY;
    end else if (op_q == OP_DEL_POS) begin
      if (COUNT_W'(pos_q) >= COUNT_W'(count_q)) status = ST_BAD_POS;
      else do_del = 1'b1;
    end else if (!any_q) begin
      status = ST_NOT_FOUND;
    end else begin
      found_out = POS_W'(found_q);
      do_del    = (op_q == OP_DEL_KEY);
    end
  end

  assign rem_cell = cell_q[del_idx[IDX_W-1:0]];
  assign rem_ext  = XW'(rem_cell);
  assign removed  = do_del ? rem_ext[VAL_W-1:0] : '0;

  always_comb begin
    count_d = count_q;
    if (cmd_i.apply && do_ins) count_d = count_q + CNT_W'(1);
    else if (cmd_i.apply && do_del) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // one-step shift of the cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.apply && do_ins && !lt_q[g]) begin
        if (g == 0) begin
          cell_q[g] <= val_q;
        end else begin
          cell_q[g] <= lt_q[(g == 0) ? 0 : g - 1] ? val_q : cell_q[(g == 0) ? 0 : g - 1];
        end
      end else if (cmd_i.apply && do_del && (g < CAPACITY - 1)) begin
        if (COUNT_W'(g) >= COUNT_W'(del_idx)) begin
          cell_q[g] <= cell_q[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_q <= {COUNT_W'(count_d), removed, found_out, status};
    end
  end

  assign out_data_o = out_q;

endmodule

// File: src/sorted_list_engine_unit.sv
// sorted_list_engine_unit: top level of the sorted list engine
// depends on sle_pkg, sle_ctrl and sle_datapath
//
// channel  dir  tdata fields (lsb first)                                     tuser
// s_axis   in   op[1:0] value[33:2] position[39:34]                          -
// m_axis   out  status[2:0] found_position[8:3] removed_value[40:9]          -
//               entry_count[47:41]
//
// every transaction has two steps: accept with a parallel compare over all cells,
// then a one-step shift of the cell row and the result register load
// one transaction is worked on at a time; a new one is taken while the result waits
// if m_axis_tready_i is high in that cycle
// reset clears the entry count, the controller state and the result valid; cell contents need no reset
`timescale 1ns / 1ps

module sorted_list_engine_unit #(
  parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [sle_pkg::IN_W-1:0]  s_axis_tdata_i,  // op, value, position
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [sle_pkg::OUT_W-1:0] m_axis_tdata_o   // status, found_position,
                                                     // removed_value, entry_count
);
  import sle_pkg::*;

  sle_cmd_t cmd;

  sle_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  sle_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// File: tb/sorted_list_engine_unit_tb.sv
// sorted_list_engine_unit_tb: self-checking bench for the sorted list engine
// needs sle_pkg and the sorted_list_engine_unit rtl; a directed table then random ops, every result
// checked against a behavioural copy of the ordered list or a typed expected result from the table
`timescale 1ns / 1ps

module sorted_list_engine_unit_tb;
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found;
    logic [VAL_W-1:0]    removed;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    int               reps;
    bit               typed;
    list_result_t     res;
  } list_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [IN_W-1:0]    s_axis_tdata_i;  // op, value, position
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [OUT_W-1:0]   m_axis_tdata_o;  // status, found_position, removed_value, entry_count

  logic signed [VAL_W-1:0] held_entries[CAP];
  int                      held_count;
  list_result_t            pending_results[$];
  list_row_t               directed_rows[$];
  int                      mismatch_count;
  bit                      no_idle;

  sorted_list_engine_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ordered list behaviour, applied once per accepted transaction
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic signed [VAL_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           i;
    int           at;
    int           hit;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_count >= CAP) begin
        r.status = ST_FULL;
      end else begin
        at = 0;
        while (at < held_count && held_entries[at] < val) at++;
        for (i = held_count; i > at; i--) held_entries[i] = held_entries[i-1];
        held_entries[at] = val;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_DEL_POS) begin
      if (pos >= held_count) begin
        r.status = ST_BAD_POS;
      end else begin
        r.removed = held_entries[pos];
        for (i = pos; i + 1 < held_count; i++) held_entries[i] = held_entries[i+1];
        held_count--;
      end
    end else begin
      hit = held_count;
      for (i = held_count - 1; i >= 0; i--) if (held_entries[i] == val) hit = i;
      if (hit == held_count) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.found = hit[POS_W-1:0];
        if (op == OP_DEL_KEY) begin
          r.removed = held_entries[hit];
          for (i = hit; i + 1 < held_count; i++) held_entries[i] = held_entries[i+1];
          held_count--;
        end
      end
    end
    r.count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                         input logic [POS_W-1:0] pos, input int reps, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [POS_W-1:0] found,
                         input logic [VAL_W-1:0] removed, input logic [COUNT_W-1:0] cnt);
    list_row_t row;
    row.op    = op;
    row.value = value;
    row.pos   = pos;
    row.reps  = reps;
    row.typed = typed;
    row.res   = '{st, found, removed, cnt};
    directed_rows.push_back(row);
  endtask

  // one transaction on the slave side, with random idle cycles ahead of it
  task automatic send_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                         input logic [POS_W-1:0] pos, input bit typed,
                         input list_result_t typed_res);
    list_result_t predicted;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 22) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pos, value, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_list_op(op, value, pos);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 5) return $signed($urandom_range(15)) - 8;
    if (r < 7) return $urandom;
    if (r == 7) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (held_count > 0) return held_entries[$urandom_range(held_count - 1)];
    return $urandom;
  endfunction

  // result side: random back-pressure and the comparison
  always @(negedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status  = m_axis_tdata_o[2:0];
      got.found   = m_axis_tdata_o[8:3];
      got.removed = m_axis_tdata_o[40:9];
      got.count   = m_axis_tdata_o[47:41];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata_o[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.found != want.found) report_mismatch("found_position", got.found, want.found);
        if (got.removed != want.removed)
          report_mismatch("removed_value", got.removed, want.removed);
        if (got.count != want.count) report_mismatch("entry_count", got.count, want.count);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    list_row_t        row;
    logic [OP_W-1:0]  op;
    int               ins_pct;
    int               n;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    rst_ni          = 1'b0;
    no_idle         = 1'b0;
    mismatch_count  = 0;
    held_count      = 0;
    for (n = 0; n < CAP; n++) held_entries[n] = '0;

    // empty list, extremes, duplicate at the head, last entry, full list, drain
    add_row(OP_SEARCH,  32'd5,         6'd0,  1, 1, ST_EMPTY,     6'd0, 32'd0, 7'd0);
    add_row(OP_DEL_POS, 32'd0,         6'd0,  1, 1, ST_EMPTY,     6'd0, 32'd0, 7'd0);
    add_row(OP_DEL_KEY, 32'd0,         6'd0,  1, 1, ST_EMPTY,     6'd0, 32'd0, 7'd0);
    add_row(OP_INSERT,  32'h7fff_ffff, 6'd0,  1, 1, ST_OK,        6'd0, 32'd0, 7'd1);
    add_row(OP_INSERT,  32'h8000_0000, 6'd63, 1, 1, ST_OK,        6'd0, 32'd0, 7'd2);
    add_row(OP_INSERT,  32'd0,         6'd0,  1, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_INSERT,  32'h8000_0000, 6'd0,  1, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_SEARCH,  32'h8000_0000, 6'd0,  1, 1, ST_OK,        6'd0, 32'd0, 7'd4);
    add_row(OP_SEARCH,  32'h7fff_ffff, 6'd0,  1, 1, ST_OK,        6'd3, 32'd0, 7'd4);
    add_row(OP_SEARCH,  32'd1234,      6'd0,  1, 1, ST_NOT_FOUND, 6'd0, 32'd0, 7'd4);
    add_row(OP_DEL_POS, 32'd0,         6'd4,  1, 1, ST_BAD_POS,   6'd0, 32'd0, 7'd4);
    add_row(OP_DEL_POS, 32'hffff_ffff, 6'd63, 1, 1, ST_BAD_POS,   6'd0, 32'd0, 7'd4);
    add_row(OP_DEL_KEY, 32'h8000_0000, 6'd0,  1, 1, ST_OK,        6'd0, 32'h8000_0000, 7'd3);
    add_row(OP_DEL_POS, 32'd0,         6'd2,  1, 1, ST_OK,        6'd0, 32'h7fff_ffff, 7'd2);
    add_row(OP_DEL_KEY, 32'd77,        6'd0,  1, 1, ST_NOT_FOUND, 6'd0, 32'd0, 7'd2);
    add_row(OP_INSERT,  32'hffff_ffff, 6'd0, 14, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_INSERT,  32'd5,         6'd0,  1, 1, ST_FULL,      6'd0, 32'd0, 7'd16);
    add_row(OP_DEL_POS, 32'd0,         6'd15, 1, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_INSERT,  32'h7fff_ffff, 6'd0,  1, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_DEL_KEY, 32'h7fff_ffff, 6'd0,  1, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_DEL_POS, 32'd0,         6'd0, 16, 0, ST_OK,        6'd0, 32'd0, 7'd0);
    add_row(OP_DEL_KEY, 32'd0,         6'd0,  1, 1, ST_EMPTY,     6'd0, 32'd0, 7'd0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      repeat (row.reps) send_op(row.op, row.value, row.pos, row.typed, row.res);
    end

    // fill level drifts between mostly inserting and mostly removing
    for (n = 0; n < 1600; n++) begin
      no_idle = (n >= 500 && n < 800);
      case ((n / 150) % 3)
        0:       ins_pct = 70;
        1:       ins_pct = 30;
        default: ins_pct = 50;
      endcase
      if ($urandom_range(99) < ins_pct) op = OP_INSERT;
      else begin
        case ($urandom_range(2))
          0:       op = OP_DEL_POS;
          1:       op = OP_SEARCH;
          default: op = OP_DEL_KEY;
        endcase
      end
      send_op(op, pick_value(),
              POS_W'(($urandom_range(9) < 8 && held_count > 0) ? $urandom_range(held_count - 1)
                                                               : $urandom_range(63)),
              1'b0, '0);
    end
    no_idle = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
src/sle_pkg.sv
src/sle_ctrl.sv
src/sle_datapath.sv
src/sorted_list_engine_unit.sv
tb/sorted_list_engine_unit_tb.sv
